/* rtl/arrt_pkg.sv */
// ----------------------------------------------------------------------------
// arrt_pkg
// Shared widths, codes and controller/datapath interface types for the
// address region range table.
// ----------------------------------------------------------------------------
package arrt_pkg;

    localparam int ADDR_W = 64;
    localparam int SIZE_W = 32;
    localparam int BAR_W  = 3;
    localparam int STAT_W = 2;
    localparam int RIDX_W = 4;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS    = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVERLAP = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the input beat and restart the scan
        logic rd_en;   // read the table entry at the scan index
        logic test;    // compare the read entry, advance the index on no match
        logic commit;  // settle the outcome and load the result register
    } arrt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;  // table holds no region
        logic last;        // scan index points at the last stored region
        logic match;       // entry just read matches the held item
        logic out_free;    // result register can take a new result
    } arrt_stat_t;

endpackage

/* rtl/address_region_range_table.sv */
// ----------------------------------------------------------------------------
// address_region_range_table
// Table of half-open address regions tagged with a window number, with
// overlap-checked insert and first-fit containment lookup.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Beat contents
//   -------  ---------  -------------------  ---------------------------------
//   in       inbound    in_valid / in_stall  opcode, bar, range_start,
//                                            range_end, access_offset,
//                                            access_size
//   out      outbound   out_valid/out_stall  status, region_index
//
// Each beat scans the stored regions from the first: the scan stops at the
// first match, otherwise it visits every stored region. Each scanned region
// takes a registered table read and then a compare, and a final step loads
// the result. The next beat can be taken in the cycle after the result is
// loaded.
// After reset the table is empty; no clearing pass is needed because only
// slots below the fill count are ever read.
// A stalled output holds its result; the next input beat is still taken and
// scanned, and only the final commit waits for the result register to free.
//
// ----------------------------------------------------------------------------
module address_region_range_table
    import arrt_pkg::*;
#(
    parameter int MAX_REGIONS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              opcode,
    input  logic [BAR_W-1:0]  bar,
    input  logic [ADDR_W-1:0] range_start,
    input  logic [ADDR_W-1:0] range_end,
    input  logic [ADDR_W-1:0] access_offset,
    input  logic [SIZE_W-1:0] access_size,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [STAT_W-1:0] status,
    output logic [RIDX_W-1:0] region_index
);

    // The controller and datapath talk only through these two bundles.
    arrt_cmd_t  cmd;
    arrt_stat_t stat;

    // The sequencer owns the input handshake: a beat is taken only while it
    // waits in its idle state.
    arrt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the region storage, the captured beat, the scan
    // index and the result register that drives the output channel.
    arrt_dpath #(
        .MAX_REGIONS (MAX_REGIONS)
    ) u_dpath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .opcode        (opcode),
        .bar           (bar),
        .range_start   (range_start),
        .range_end     (range_end),
        .access_offset (access_offset),
        .access_size   (access_size),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .region_index  (region_index)
    );

endmodule

/* rtl/arrt_ctrl.sv */
// ----------------------------------------------------------------------------
// arrt_ctrl
// Sequencer for the region table: accepts one beat, steps the table scan
// and commits the outcome once the result register is free.
// ----------------------------------------------------------------------------
module arrt_ctrl
    import arrt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  arrt_stat_t stat,
    output arrt_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_READ   = 2'd1;
    localparam logic [1:0] S_TEST   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.count_zero ? S_FINISH : S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_TEST;
            end
            S_TEST:
            begin
                cmd.test = 1'b1;
                if (stat.match || stat.last)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

/* rtl/arrt_dpath.sv */
// ----------------------------------------------------------------------------
// arrt_dpath
// Region storage, held item, scan index, entry compare and result register
// for the region table.
// ----------------------------------------------------------------------------
module arrt_dpath
    import arrt_pkg::*;
#(
    parameter int MAX_REGIONS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  arrt_cmd_t         cmd,
    output arrt_stat_t        stat,
    input  logic              opcode,
    input  logic [BAR_W-1:0]  bar,
    input  logic [ADDR_W-1:0] range_start,
    input  logic [ADDR_W-1:0] range_end,
    input  logic [ADDR_W-1:0] access_offset,
    input  logic [SIZE_W-1:0] access_size,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [STAT_W-1:0] status,
    output logic [RIDX_W-1:0] region_index
);

    localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W = $clog2(MAX_REGIONS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REGIONS);

    logic [BAR_W-1:0]  mem_window [MAX_REGIONS];
    logic [ADDR_W-1:0] mem_first  [MAX_REGIONS];
    logic [ADDR_W-1:0] mem_limit  [MAX_REGIONS];

    logic [BAR_W-1:0]  rd_window_reg;
    logic [ADDR_W-1:0] rd_first_reg;
    logic [ADDR_W-1:0] rd_limit_reg;

    logic              op_reg;
    logic [BAR_W-1:0]  bar_reg;
    logic [ADDR_W-1:0] lo_reg;
    logic [ADDR_W-1:0] hi_reg;
    logic              bad_reg;

    logic [CNT_W-1:0]  count_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              hit_reg;
    logic              out_valid_reg;
    logic [STAT_W-1:0] status_reg;
    logic [RIDX_W-1:0] index_reg;

    logic [STAT_W-1:0] status_next;
    logic [RIDX_W-1:0] index_next;
    logic              do_write;
    logic              full;
    logic              match;
    logic              overlap;
    logic              contain;
    logic [ADDR_W:0]   stop_sum;
    logic [IDX_W+RIDX_W-1:0] idx_wide;
    logic [IDX_W+RIDX_W-1:0] cnt_wide;

    // Access end, one bit wider so that a wrap past the top is seen.
    assign stop_sum = {1'b0, access_offset} + {{(ADDR_W - SIZE_W + 1){1'b0}}, access_size};

    assign full = (count_reg == CNT_MAX);

    assign overlap = !((hi_reg <= rd_first_reg) || (rd_limit_reg <= lo_reg));
    assign contain = !bad_reg && (lo_reg >= rd_first_reg) && (hi_reg <= rd_limit_reg);
    assign match   = (rd_window_reg == bar_reg) && ((op_reg == OP_LOOKUP) ? contain : overlap);

    assign idx_wide = {{RIDX_W{1'b0}}, idx_reg};
    assign cnt_wide = {{RIDX_W{1'b0}}, count_reg[IDX_W-1:0]};

    always_comb
    begin
        do_write    = 1'b0;
        status_next = ST_MISS;
        index_next  = '0;
        if (hit_reg)
        begin
            if (op_reg == OP_LOOKUP)
            begin
                status_next = ST_OK;
                index_next  = idx_wide[RIDX_W-1:0];
            end
            else
            begin
                status_next = ST_OVERLAP;
            end
        end
        else if (op_reg == OP_INSERT)
        begin
            if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                status_next = ST_OK;
                index_next  = cnt_wide[RIDX_W-1:0];
                do_write    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg <= '0;
                hit_reg <= 1'b0;
            end
            else if (cmd.test)
            begin
                hit_reg <= match;
                if (!match)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            if (cmd.commit && do_write)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            bar_reg <= bar;
            if (opcode == OP_LOOKUP)
            begin
                lo_reg  <= access_offset;
                hi_reg  <= stop_sum[ADDR_W-1:0];
                bad_reg <= (access_size == '0) || stop_sum[ADDR_W];
            end
            else
            begin
                lo_reg  <= range_start;
                hi_reg  <= range_end;
                bad_reg <= 1'b0;
            end
        end
        if (cmd.commit)
        begin
            status_reg <= status_next;
            index_reg  <= index_next;
        end
    end

    // Region storage: one write port at the fill count, one registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.commit && do_write)
        begin
            mem_window[count_reg[IDX_W-1:0]] <= bar_reg;
            mem_first[count_reg[IDX_W-1:0]]  <= lo_reg;
            mem_limit[count_reg[IDX_W-1:0]]  <= hi_reg;
        end
        if (cmd.rd_en)
        begin
            rd_window_reg <= mem_window[idx_reg];
            rd_first_reg  <= mem_first[idx_reg];
            rd_limit_reg  <= mem_limit[idx_reg];
        end
    end

    assign stat.count_zero = (count_reg == '0);
    assign stat.last       = ((CNT_W'(idx_reg) + 1'b1) == count_reg);
    assign stat.match      = match;
    assign stat.out_free   = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign region_index = index_reg;

endmodule
